// File: rtl/gtal_pkg.sv
// Package with shared constants, reset values and types of the gas and temperature alarm.
`default_nettype none

package gtal_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_WINDOW_LEN          = 10;
    localparam int DEF_SAMPLE_PERIOD_TICKS = 10;
    localparam int DEF_ADC_BITS            = 12;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register widths.
    localparam int CODE_W  = 4;
    localparam int LIMIT_W = 16;
    localparam int BLINK_W = 8;
    localparam int SMALL_W = 3;

    // Register reset values.
    localparam logic [CODE_W-1:0]  RST_UNLOCK_CODE      = 4'd3;
    localparam logic [LIMIT_W-1:0] RST_OVERHEAT_LIMIT   = 16'd6206;
    localparam logic [BLINK_W-1:0] RST_GAS_BLINK_TICKS  = 8'd100;
    localparam logic [BLINK_W-1:0] RST_TEMP_BLINK_TICKS = 8'd50;
    localparam logic [BLINK_W-1:0] RST_BOTH_BLINK_TICKS = 8'd10;
    localparam logic [SMALL_W-1:0] RST_DEBOUNCE_TICKS   = 3'd4;
    localparam logic [SMALL_W-1:0] RST_MAX_WRONG_CODES  = 3'd5;

    // Saturation points of the counters.
    localparam logic [SMALL_W-1:0] SMALL_CNT_MAX = 3'd7;
    localparam logic [BLINK_W-1:0] BLINK_CNT_MAX = 8'd255;

    // Result beat layout.
    localparam int OUT_FIELDS_W = 5;
    localparam int OUT_TDATA_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNLOCK_CODE      = 3'd0,
        CFG_OVERHEAT_LIMIT   = 3'd1,
        CFG_GAS_BLINK_TICKS  = 3'd2,
        CFG_TEMP_BLINK_TICKS = 3'd3,
        CFG_BOTH_BLINK_TICKS = 3'd4,
        CFG_DEBOUNCE_TICKS   = 3'd5,
        CFG_MAX_WRONG_CODES  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_UP        = 2'd0,
        PH_DOWN      = 2'd1,
        PH_PRESSING  = 2'd2,
        PH_RELEASING = 2'd3
    } t_dbnc_phase;

endpackage

`default_nettype wire

// File: rtl/gtal_window.sv
// Temperature sample window: decimation counter, sliding window, running sum and over-temperature flag.
`default_nettype none

module gtal_window
    import gtal_pkg::*;
#(
    parameter int WINDOW_LEN          = DEF_WINDOW_LEN,
    parameter int SAMPLE_PERIOD_TICKS = DEF_SAMPLE_PERIOD_TICKS,
    parameter int ADC_BITS            = DEF_ADC_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_tick,
    input  wire logic [ADC_BITS-1:0] i_sample,
    input  wire logic [LIMIT_W-1:0]  i_limit,
    output logic                     o_overheat_nxt
);

    localparam int IDX_W  = $clog2(WINDOW_LEN);
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int CNT_W  = (SAMPLE_PERIOD_TICKS > 1) ? $clog2(SAMPLE_PERIOD_TICKS) : 1;
    localparam int SUM_W  = ADC_BITS + IDX_W;
    localparam int CMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(WINDOW_LEN);
    localparam logic [IDX_W:0]    SLOT_END   = (IDX_W + 1)'(WINDOW_LEN);
    localparam logic [CNT_W:0]    PERIOD_END = (CNT_W + 1)'(SAMPLE_PERIOD_TICKS);

    logic [ADC_BITS-1:0] r_window [WINDOW_LEN];
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic [CNT_W-1:0]    r_tick_cnt, n_tick_cnt;
    logic                r_overheat;

    logic                take;
    logic                full;
    logic [IDX_W-1:0]    wr_addr;
    logic [ADC_BITS-1:0] oldest;
    logic [CNT_W:0]      tick_inc;
    logic [IDX_W:0]      slot_inc;

    assign full     = (r_fill >= FILL_FULL);
    assign tick_inc = {1'b0, r_tick_cnt} + 1'b1;
    assign take     = i_tick && (tick_inc >= PERIOD_END);
    assign wr_addr  = full ? r_slot : r_fill[IDX_W-1:0];
    assign oldest   = r_window[r_slot];
    assign slot_inc = {1'b0, r_slot} + 1'b1;

    always_comb begin
        n_tick_cnt     = r_tick_cnt;
        n_sum          = r_sum;
        n_fill         = r_fill;
        n_slot         = r_slot;
        o_overheat_nxt = r_overheat;
        if (i_tick) begin
            n_tick_cnt = take ? '0 : tick_inc[CNT_W-1:0];
        end
        if (take) begin
            if (!full) begin
                n_sum  = r_sum + SUM_W'(i_sample);
                n_fill = r_fill + 1'b1;
            end else begin
                // The oldest slot has been written during the first fill.
                n_sum          = r_sum - SUM_W'(oldest) + SUM_W'(i_sample);
                n_slot         = (slot_inc >= SLOT_END) ? '0 : slot_inc[IDX_W-1:0];
                o_overheat_nxt = (CMP_W'(n_sum) > CMP_W'(i_limit));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_fill     <= '0;
            r_slot     <= '0;
            r_tick_cnt <= '0;
            r_overheat <= 1'b0;
        end else begin
            r_sum      <= n_sum;
            r_fill     <= n_fill;
            r_slot     <= n_slot;
            r_tick_cnt <= n_tick_cnt;
            r_overheat <= o_overheat_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_window[wr_addr] <= i_sample;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gas_temp_alarm_with_code_lock.sv
// Top level of the gas and temperature alarm with a code lock.
//
// One input beat stands for one 10 ms tick. s_axis_tdata carries the gas level,
// the enter button level, the four code buttons and a temperature ADC sample.
// Each accepted beat produces exactly one result beat on the master side with
// the alarm LED, error LED, blocked LED, alarm state and over-temperature flag.
// The result of an accepted beat is registered at the edge that accepts it and is
// valid in the next cycle. One beat is taken per cycle while the receiver takes
// each result; all per-tick work is a single pass of logic from the accepted beat
// into the state and the result register.
// The result register parts the two sides: a new beat is accepted whenever the
// result register is empty or is being taken in the same cycle. While the
// receiver stalls, the pending result holds and at most one further beat waits
// upstream.
// The configuration port writes one register per enabled clock edge. It is to be
// used only while no beat is in flight; the block itself does not enforce this.
// Reset (synchronous, active low) restores every register to its default,
// empties the sample window and clears the alarm, debounce and lockout state.
`default_nettype none

module gas_temp_alarm_with_code_lock
    import gtal_pkg::*;
#(
    parameter int WINDOW_LEN          = DEF_WINDOW_LEN,
    parameter int SAMPLE_PERIOD_TICKS = DEF_SAMPLE_PERIOD_TICKS,
    parameter int ADC_BITS            = DEF_ADC_BITS,
    localparam int IN_FIELDS_W        = 6 + ADC_BITS,
    localparam int IN_TDATA_W         = ((IN_FIELDS_W + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // bit 0 gas_present, bit 1 enter_level, code_buttons, temp_sample, zero fill
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // bit 0 alarm_led, wrong_code_led, blocked_led, alarm_active, overheat, zero fill
    output logic [OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [CODE_W-1:0]  r_unlock_code;
    logic [LIMIT_W-1:0] r_limit;
    logic [BLINK_W-1:0] r_gas_blink;
    logic [BLINK_W-1:0] r_temp_blink;
    logic [BLINK_W-1:0] r_both_blink;
    logic [SMALL_W-1:0] r_dbnc_ticks;
    logic [SMALL_W-1:0] r_max_wrong;

    // Alarm, blink, debounce and lockout state.
    logic               r_alarm, n_alarm;
    logic               r_gas_l, n_gas_l;
    logic               r_heat_l, n_heat_l;
    logic               r_led, n_led;
    logic [BLINK_W-1:0] r_blink_cnt, n_blink_cnt;
    t_dbnc_phase        r_phase, n_phase;
    logic [SMALL_W-1:0] r_dbnc_cnt, n_dbnc_cnt;
    logic [SMALL_W-1:0] r_wrong, n_wrong;
    logic               r_err_led, n_err_led;
    logic [1:0]         r_rel_cnt, n_rel_cnt;

    // Result register.
    logic                    r_m_valid;
    logic [OUT_TDATA_W-1:0]  r_m_data, n_m_data;

    logic                s_fire;
    logic                in_gas;
    logic                in_enter;
    logic [CODE_W-1:0]   in_buttons;
    logic [ADC_BITS-1:0] in_sample;
    logic                overheat_nxt;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign in_gas     = s_axis_tdata[0];
    assign in_enter   = s_axis_tdata[1];
    assign in_buttons = s_axis_tdata[5:2];
    assign in_sample  = s_axis_tdata[6 +: ADC_BITS];

    gtal_window #(
        .WINDOW_LEN          (WINDOW_LEN),
        .SAMPLE_PERIOD_TICKS (SAMPLE_PERIOD_TICKS),
        .ADC_BITS            (ADC_BITS)
    ) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (s_fire),
        .i_sample       (in_sample),
        .i_limit        (r_limit),
        .o_overheat_nxt (overheat_nxt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlock_code <= RST_UNLOCK_CODE;
            r_limit       <= RST_OVERHEAT_LIMIT;
            r_gas_blink   <= RST_GAS_BLINK_TICKS;
            r_temp_blink  <= RST_TEMP_BLINK_TICKS;
            r_both_blink  <= RST_BOTH_BLINK_TICKS;
            r_dbnc_ticks  <= RST_DEBOUNCE_TICKS;
            r_max_wrong   <= RST_MAX_WRONG_CODES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UNLOCK_CODE:      r_unlock_code <= i_cfg_data[CODE_W-1:0];
                CFG_OVERHEAT_LIMIT:   r_limit       <= i_cfg_data[LIMIT_W-1:0];
                CFG_GAS_BLINK_TICKS:  r_gas_blink   <= i_cfg_data[BLINK_W-1:0];
                CFG_TEMP_BLINK_TICKS: r_temp_blink  <= i_cfg_data[BLINK_W-1:0];
                CFG_BOTH_BLINK_TICKS: r_both_blink  <= i_cfg_data[BLINK_W-1:0];
                CFG_DEBOUNCE_TICKS:   r_dbnc_ticks  <= i_cfg_data[SMALL_W-1:0];
                CFG_MAX_WRONG_CODES:  r_max_wrong   <= i_cfg_data[SMALL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        logic [BLINK_W-1:0] period;
        logic               release_evt;
        logic [1:0]         rel_inc;

        n_alarm     = r_alarm;
        n_gas_l     = r_gas_l;
        n_heat_l    = r_heat_l;
        n_led       = r_led;
        n_blink_cnt = r_blink_cnt;
        n_phase     = r_phase;
        n_dbnc_cnt  = r_dbnc_cnt;
        n_wrong     = r_wrong;
        n_err_led   = r_err_led;
        n_rel_cnt   = r_rel_cnt;
        release_evt = 1'b0;
        rel_inc     = r_rel_cnt + 1'b1;
        period      = r_temp_blink;

        if (s_fire) begin
            if (in_gas) begin
                n_gas_l = 1'b1;
                n_alarm = 1'b1;
            end
            if (overheat_nxt) begin
                n_heat_l = 1'b1;
                n_alarm  = 1'b1;
            end

            if (n_alarm) begin
                if (n_gas_l && n_heat_l) begin
                    period = r_both_blink;
                end else if (n_gas_l) begin
                    period = r_gas_blink;
                end
                if (r_blink_cnt < BLINK_CNT_MAX) begin
                    n_blink_cnt = r_blink_cnt + 1'b1;
                end
                if ((n_gas_l || n_heat_l) && (n_blink_cnt >= period)) begin
                    n_blink_cnt = '0;
                    n_led       = !r_led;
                end
            end else begin
                n_led    = 1'b0;
                n_gas_l  = 1'b0;
                n_heat_l = 1'b0;
            end

            // Button handling stops once the wrong-code limit is reached, until reset or a higher limit is written.
            if (r_wrong < r_max_wrong) begin
                case (r_phase)
                    PH_UP: begin
                        if (in_enter) begin
                            n_phase    = PH_PRESSING;
                            n_dbnc_cnt = '0;
                        end
                    end
                    PH_DOWN: begin
                        if (!in_enter) begin
                            n_phase    = PH_RELEASING;
                            n_dbnc_cnt = '0;
                        end
                    end
                    PH_PRESSING: begin
                        if (r_dbnc_cnt >= r_dbnc_ticks) begin
                            n_phase = in_enter ? PH_DOWN : PH_UP;
                        end
                        if (r_dbnc_cnt < SMALL_CNT_MAX) begin
                            n_dbnc_cnt = r_dbnc_cnt + 1'b1;
                        end
                    end
                    PH_RELEASING: begin
                        if (r_dbnc_cnt >= r_dbnc_ticks) begin
                            n_phase     = in_enter ? PH_DOWN : PH_UP;
                            release_evt = !in_enter;
                        end
                        if (r_dbnc_cnt < SMALL_CNT_MAX) begin
                            n_dbnc_cnt = r_dbnc_cnt + 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_UP;
                    end
                endcase
            end

            // A debounced release either counts toward clearing the error LED
            // or, with the alarm on, checks the code.
            if (release_evt) begin
                if (r_err_led) begin
                    if (rel_inc >= 2'd2) begin
                        n_err_led = 1'b0;
                        n_rel_cnt = '0;
                    end else begin
                        n_rel_cnt = rel_inc;
                    end
                end else if (n_alarm) begin
                    if (in_buttons == r_unlock_code) begin
                        n_alarm = 1'b0;
                        n_wrong = '0;
                    end else begin
                        n_err_led = 1'b1;
                        if (r_wrong < SMALL_CNT_MAX) begin
                            n_wrong = r_wrong + 1'b1;
                        end
                    end
                end
            end
        end

        n_m_data = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                    overheat_nxt, n_alarm, (n_wrong >= r_max_wrong), n_err_led, n_led};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm     <= 1'b0;
            r_gas_l     <= 1'b0;
            r_heat_l    <= 1'b0;
            r_led       <= 1'b0;
            r_blink_cnt <= '0;
            r_phase     <= PH_UP;
            r_dbnc_cnt  <= '0;
            r_wrong     <= '0;
            r_err_led   <= 1'b0;
            r_rel_cnt   <= '0;
        end else begin
            r_alarm     <= n_alarm;
            r_gas_l     <= n_gas_l;
            r_heat_l    <= n_heat_l;
            r_led       <= n_led;
            r_blink_cnt <= n_blink_cnt;
            r_phase     <= n_phase;
            r_dbnc_cnt  <= n_dbnc_cnt;
            r_wrong     <= n_wrong;
            r_err_led   <= n_err_led;
            r_rel_cnt   <= n_rel_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_fire) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_m_data <= n_m_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gtal_checker.sv
// Port-level checks of the alarm block and the bind that attaches them to the top level.
`default_nettype none

module gtal_checker
    import gtal_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Reset empties the result register at the next edge.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Every accepted beat leaves a result waiting in the next cycle.
    a_beat_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

    // Input is held back only by a result that is waiting.
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a pending result");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind gas_temp_alarm_with_code_lock gtal_checker u_gtal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: verif/gas_temp_alarm_with_code_lock_test.sv
// Self-checking stream testbench for the gas and temperature alarm with its code lock.
module gas_temp_alarm_with_code_lock_test
    import gtal_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_LEN        = DEF_WINDOW_LEN;
    localparam int SAMPLE_PERIOD  = DEF_SAMPLE_PERIOD_TICKS;
    localparam int TICK_TDATA_W   = ((6 + DEF_ADC_BITS + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic        gas;
        logic        enter;
        logic [3:0]  buttons;
        logic [11:0] temp;
    } t_tick_item;

    typedef struct packed {
        logic alarm_led;
        logic wrong_code_led;
        logic blocked_led;
        logic alarm_active;
        logic overheat;
    } t_lamps;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // bit 0 gas_present, bit 1 enter_level, code_buttons, temp_sample, zero fill
    logic [TICK_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // bit 0 alarm_led, wrong_code_led, blocked_led, alarm_active, overheat, zero fill
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    gas_temp_alarm_with_code_lock u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Register copies, kept in step with every write.
    logic [CODE_W-1:0]  reg_code       = RST_UNLOCK_CODE;
    logic [LIMIT_W-1:0] reg_limit      = RST_OVERHEAT_LIMIT;
    logic [BLINK_W-1:0] reg_gas_blink  = RST_GAS_BLINK_TICKS;
    logic [BLINK_W-1:0] reg_temp_blink = RST_TEMP_BLINK_TICKS;
    logic [BLINK_W-1:0] reg_both_blink = RST_BOTH_BLINK_TICKS;
    logic [SMALL_W-1:0] reg_dbnc       = RST_DEBOUNCE_TICKS;
    logic [SMALL_W-1:0] reg_max_wrong  = RST_MAX_WRONG_CODES;

    // Alarm state as the block should hold it.
    int unsigned  win [WIN_LEN];
    int unsigned  win_sum     = 0;
    int           win_fill    = 0;
    int           win_oldest  = 0;
    int           tick_count  = 0;
    logic         hot         = 1'b0;
    logic         alarm       = 1'b0;
    logic         gas_seen    = 1'b0;
    logic         heat_seen   = 1'b0;
    logic         led         = 1'b0;
    logic [7:0]   blink_cnt   = '0;
    t_dbnc_phase  phase       = PH_UP;
    logic [2:0]   dbnc_cnt    = '0;
    logic [2:0]   wrong_cnt   = '0;
    logic         err_led     = 1'b0;
    logic [1:0]   release_cnt = '0;

    t_lamps pending_lamps [$];
    t_lamps want_lamps;
    t_lamps got_lamps;
    int     err_count     = 0;
    int     quiet_cycles  = 0;
    int     rx_hold_cycles = 0;
    int     rx_stall_left = 0;
    bit     tx_idling     = 1'b1;
    bit     rx_idling     = 1'b1;

    function automatic t_lamps predict_lamps(t_tick_item t);
        t_lamps     r;
        logic [7:0] period;
        tick_count++;
        if (tick_count >= SAMPLE_PERIOD) begin
            tick_count = 0;
            if (win_fill < WIN_LEN) begin
                win[win_fill] = t.temp;
                win_sum += t.temp;
                win_fill++;
            end else begin
                // Over-temperature only moves when a sample replaces an old one.
                win_sum = win_sum - win[win_oldest] + t.temp;
                win[win_oldest] = t.temp;
                win_oldest = (win_oldest + 1 >= WIN_LEN) ? 0 : win_oldest + 1;
                hot = (win_sum > reg_limit);
            end
        end
        if (t.gas) begin
            gas_seen = 1'b1;
            alarm = 1'b1;
        end
        if (hot) begin
            heat_seen = 1'b1;
            alarm = 1'b1;
        end
        if (alarm) begin
            period = (gas_seen && heat_seen) ? reg_both_blink :
                     gas_seen ? reg_gas_blink : reg_temp_blink;
            if (blink_cnt != BLINK_CNT_MAX) blink_cnt++;
            if ((gas_seen || heat_seen) && blink_cnt >= period) begin
                blink_cnt = '0;
                led = ~led;
            end
        end else begin
            led = 1'b0;
            gas_seen = 1'b0;
            heat_seen = 1'b0;
        end
        if (wrong_cnt < reg_max_wrong) begin
            case (phase)
                PH_UP: begin
                    if (t.enter) begin
                        phase = PH_PRESSING;
                        dbnc_cnt = '0;
                    end
                end
                PH_DOWN: begin
                    if (!t.enter) begin
                        phase = PH_RELEASING;
                        dbnc_cnt = '0;
                    end
                end
                PH_PRESSING: begin
                    if (dbnc_cnt >= reg_dbnc) phase = t.enter ? PH_DOWN : PH_UP;
                    if (dbnc_cnt != SMALL_CNT_MAX) dbnc_cnt++;
                end
                default: begin
                    if (dbnc_cnt >= reg_dbnc) begin
                        if (t.enter) begin
                            phase = PH_DOWN;
                        end else begin
                            phase = PH_UP;
                            // A lit error LED eats two releases before codes count again.
                            if (err_led) begin
                                release_cnt++;
                                if (release_cnt >= 2) begin
                                    err_led = 1'b0;
                                    release_cnt = '0;
                                end
                            end else if (alarm) begin
                                if (t.buttons == reg_code) begin
                                    alarm = 1'b0;
                                    wrong_cnt = '0;
                                end else begin
                                    err_led = 1'b1;
                                    if (wrong_cnt != SMALL_CNT_MAX) wrong_cnt++;
                                end
                            end
                        end
                    end
                    if (dbnc_cnt != SMALL_CNT_MAX) dbnc_cnt++;
                end
            endcase
        end
        r.alarm_led      = led;
        r.wrong_code_led = err_led;
        r.blocked_led    = (wrong_cnt >= reg_max_wrong);
        r.alarm_active   = alarm;
        r.overheat       = hot;
        return r;
    endfunction

    task automatic send_tick(input t_tick_item t);
        @(negedge i_clk);
        if (tx_idling && $urandom_range(0, 11) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TICK_TDATA_W'({t.temp, t.buttons, t.enter, t.gas});
        do @(posedge i_clk); while (!s_axis_tready);
        pending_lamps.push_back(predict_lamps(t));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_lamps.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
    endtask

    task automatic apply_settings(input logic [3:0] code, input logic [15:0] limit,
                                  input logic [7:0] gas_blink, input logic [7:0] temp_blink,
                                  input logic [7:0] both_blink, input logic [2:0] dbnc,
                                  input logic [2:0] max_wrong);
        write_reg(CFG_UNLOCK_CODE, CFG_DATA_W'(code));
        write_reg(CFG_OVERHEAT_LIMIT, limit);
        write_reg(CFG_GAS_BLINK_TICKS, CFG_DATA_W'(gas_blink));
        write_reg(CFG_TEMP_BLINK_TICKS, CFG_DATA_W'(temp_blink));
        write_reg(CFG_BOTH_BLINK_TICKS, CFG_DATA_W'(both_blink));
        write_reg(CFG_DEBOUNCE_TICKS, CFG_DATA_W'(dbnc));
        write_reg(CFG_MAX_WRONG_CODES, CFG_DATA_W'(max_wrong));
        @(negedge i_clk);
        i_cfg_we       <= 1'b0;
        reg_code       = code;
        reg_limit      = limit;
        reg_gas_blink  = gas_blink;
        reg_temp_blink = temp_blink;
        reg_both_blink = both_blink;
        reg_dbnc       = dbnc;
        reg_max_wrong  = max_wrong;
    endtask

    // One clean press and release with the buttons held at the given code.
    task automatic enter_code(input logic [3:0] code, input logic gas);
        t_tick_item t;
        int         hold;
        hold = reg_dbnc + 2;
        for (int j = 0; j < 2 * hold; j++) begin
            t.gas     = gas && (j == 0);
            t.enter   = (j < hold);
            t.buttons = code;
            t.temp    = 12'($urandom_range(0, 4095));
            send_tick(t);
        end
    endtask

    // Mostly well-formed code entries, with bounces, quiet spells and noise between.
    task automatic run_random(input int n_items, input int gas_odds, input int temp_hi);
        t_tick_item t;
        int         sent;
        int         kind;
        int         hold_len;
        int         rel_len;
        logic [3:0] seg_code;
        sent = 0;
        while (sent < n_items) begin
            kind     = $urandom_range(0, 9);
            hold_len = reg_dbnc + $urandom_range(2, 4);
            rel_len  = reg_dbnc + $urandom_range(2, 5);
            if ($urandom_range(0, 4) == 0) hold_len = $urandom_range(1, reg_dbnc + 1);
            else if ($urandom_range(0, 4) == 0) rel_len = $urandom_range(1, reg_dbnc + 1);
            if (kind >= 6) hold_len = $urandom_range(1, 12);
            seg_code = $urandom_range(0, 1) ? reg_code : 4'($urandom);
            for (int j = 0; j < hold_len + rel_len; j++) begin
                t.gas  = ($urandom_range(0, gas_odds) == 0);
                t.temp = ($urandom_range(0, 19) == 0) ? {12{1'($urandom)}} :
                         12'($urandom_range(0, temp_hi));
                if (kind <= 5) begin
                    t.enter   = (j < hold_len);
                    t.buttons = seg_code;
                end else if (kind <= 7) begin
                    t.enter   = 1'b0;
                    t.buttons = 4'($urandom);
                end else begin
                    t.enter   = 1'($urandom);
                    t.buttons = 4'($urandom);
                end
                // A seventh wrong code would lock the block for good.
                if (wrong_cnt >= 3'd6) t.buttons = reg_code;
                send_tick(t);
                sent++;
            end
        end
    endtask

    task automatic test_field_extremes();
        send_tick('{gas: 1'b0, enter: 1'b0, buttons: 4'h0, temp: 12'h000});
        send_tick('{gas: 1'b0, enter: 1'b0, buttons: 4'hF, temp: 12'hFFF});
        send_tick('{gas: 1'b1, enter: 1'b1, buttons: 4'hF, temp: 12'hFFF});
        send_tick('{gas: 1'b0, enter: 1'b0, buttons: 4'h0, temp: 12'h000});
        drain_results();
    endtask

    task automatic test_code_entry();
        apply_settings(4'hA, RST_OVERHEAT_LIMIT, 8'd1, 8'd2, 8'd3, 3'd1, 3'd5);
        enter_code(4'h5, 1'b1);
        enter_code(4'hA, 1'b0);
        enter_code(4'h0, 1'b0);
        enter_code(4'hA, 1'b0);
        drain_results();
    endtask

    task automatic test_lockout();
        apply_settings(4'h6, RST_OVERHEAT_LIMIT, 8'd3, 8'd4, 8'd2, 3'd2, 3'd2);
        enter_code(4'h9, 1'b1);
        enter_code(4'h9, 1'b0);
        enter_code(4'h9, 1'b0);
        enter_code(4'h9, 1'b1);
        // Blocked now: presses must be ignored.
        enter_code(4'h6, 1'b1);
        drain_results();
        apply_settings(4'h6, RST_OVERHEAT_LIMIT, 8'd3, 8'd4, 8'd2, 3'd2, 3'd7);
        enter_code(4'h1, 1'b0);
        enter_code(4'h2, 1'b0);
        enter_code(4'h6, 1'b1);
        drain_results();
    endtask

    task automatic test_random_settings();
        int temp_hi;
        for (int p = 0; p < 7; p++) begin
            if (p == 0) begin
                apply_settings(4'h0, 16'd0, 8'd1, 8'd1, 8'd1, 3'd1, 3'd7);
            end else if (p == 1) begin
                apply_settings(4'hF, 16'd40950, 8'd255, 8'd255, 8'd255, 3'd7, 3'd1);
            end else begin
                apply_settings(4'($urandom), 16'($urandom_range(0, 40950)),
                               $urandom_range(0, 1) ? 8'($urandom_range(1, 12))
                                                    : 8'($urandom_range(1, 255)),
                               $urandom_range(0, 1) ? 8'($urandom_range(1, 12))
                                                    : 8'($urandom_range(1, 255)),
                               8'($urandom_range(1, 255)),
                               3'($urandom_range(1, 7)), 3'($urandom_range(2, 7)));
            end
            // Samples up to a fifth of the limit, a tenth on average, keep the window sum wandering across it.
            temp_hi = reg_limit / 5;
            if (temp_hi > 4095 || $urandom_range(0, 2) == 0) temp_hi = 4095;
            if (temp_hi == 0) temp_hi = 1;
            run_random(130, $urandom_range(2, 40), temp_hi);
            drain_results();
        end
    endtask

    task automatic test_result_backpressure();
        tx_idling = 1'b0;
        rx_hold_cycles = 120;
        run_random(40, 4, 4095);
        drain_results();
        tx_idling = 1'b1;
    endtask

    task automatic test_steady_stream();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        run_random(150, 6, 4095);
        drain_results();
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_field_extremes();
        test_code_entry();
        test_lockout();
        test_random_settings();
        test_result_backpressure();
        test_steady_stream();
        if (err_count == 0 && pending_lamps.size() == 0) begin
            $display("gas_temp_alarm_with_code_lock_test: PASS");
        end else begin
            $display("gas_temp_alarm_with_code_lock_test: FAIL");
        end
        $finish;
    end

    // Result side: random stall bursts, plus a long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (rx_stall_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_stall_left--;
            end else if (rx_idling && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                rx_stall_left = $urandom_range(1, 10) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_lamps.alarm_led      = m_axis_tdata[0];
            got_lamps.wrong_code_led = m_axis_tdata[1];
            got_lamps.blocked_led    = m_axis_tdata[2];
            got_lamps.alarm_active   = m_axis_tdata[3];
            got_lamps.overheat       = m_axis_tdata[4];
            if (pending_lamps.size() == 0) begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("unexpected result beat: %b", m_axis_tdata);
            end else begin
                want_lamps = pending_lamps.pop_front();
                if (got_lamps !== want_lamps) begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display({"lamp mismatch: expected led=%b err=%b blocked=%b alarm=%b ",
                                  "hot=%b, got led=%b err=%b blocked=%b alarm=%b hot=%b"},
                                 want_lamps.alarm_led, want_lamps.wrong_code_led,
                                 want_lamps.blocked_led, want_lamps.alarm_active,
                                 want_lamps.overheat, got_lamps.alarm_led,
                                 got_lamps.wrong_code_led, got_lamps.blocked_led,
                                 got_lamps.alarm_active, got_lamps.overheat);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("gas_temp_alarm_with_code_lock_test: FAIL");
                $finish;
            end
        end
    end

endmodule
